// ----- hdl/sliding_window_min_max_mean_top_defines.svh -----
// ---------------------------------------------------------------------------
// Sliding window min/max/mean: assertion macros
// Shared property wrappers, clocked on aclk and disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define SWMM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define SWMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/swmm_pkg.sv -----
// ---------------------------------------------------------------------------
// Sliding window min/max/mean: package
// Field widths, constants and shared types.
// ---------------------------------------------------------------------------
package swmm_pkg;

    localparam int MAX_WINDOW_DEF = 8;

    localparam int TEMP_W   = 16;
    localparam int PULSE_W  = 8;
    localparam int SAT_W    = 7;
    localparam int CFG_W    = 4;
    localparam int HELD_W   = 4;
    localparam int PMEAN_W  = 12;
    localparam int SMEAN_W  = 11;
    localparam int FRAC_W   = 4;
    localparam int QUO_W    = 16;
    localparam int QCNT_W   = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [CFG_W-1:0]     RESET_WINDOW = 4'd5;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 1'b0;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN_INIT = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_INIT = 16'sh8000;
    localparam logic [PULSE_W-1:0]       PULSE_MIN_INIT = 8'hFF;
    localparam logic [SAT_W-1:0]         SAT_MIN_INIT   = 7'h7F;

    // mean selected for the shared divider
    localparam logic [1:0] DIV_TEMP  = 2'd0;
    localparam logic [1:0] DIV_PULSE = 2'd1;
    localparam logic [1:0] DIV_SAT   = 2'd2;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PULSE_W-1:0]       pulse;
        logic [SAT_W-1:0]         sat;
    } reading_t;

    typedef struct packed {
        logic clr;
        logic wr;
        logic rd;
        logic acc;
    } hist_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] tmin;
        logic signed [TEMP_W-1:0] tmax;
        logic [PULSE_W-1:0]       pmin;
        logic [PULSE_W-1:0]       pmax;
        logic [SAT_W-1:0]         smin;
        logic [SAT_W-1:0]         smax;
    } extremes_t;

    typedef struct packed {
        extremes_t                ext;
        logic signed [TEMP_W-1:0] tmean;
        logic [PMEAN_W-1:0]       pmean;
        logic [SMEAN_W-1:0]       smean;
        logic [HELD_W-1:0]        held;
    } result_t;

endpackage

// ----- hdl/swmm_hist.sv -----
// ---------------------------------------------------------------------------
// Sliding window min/max/mean: history store and scan unit
// Reading memory with registered read port, and one compare/add unit that
// folds one stored reading per cycle, while acc is set, into min, max and sum.
// ---------------------------------------------------------------------------
module swmm_hist import swmm_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int AW         = 3,
    parameter int FW         = 4
) (
    input  logic                          aclk,
    input  hist_ctrl_t                    ctrl,
    input  logic [AW-1:0]                 addr,
    input  reading_t                      wr_data,
    output extremes_t                     ext,
    output logic signed [TEMP_W+FW-1:0]   tsum,
    output logic [PULSE_W+FW-1:0]         psum,
    output logic [SAT_W+FW-1:0]           ssum
);

    localparam int TSW = TEMP_W + FW;
    localparam int PSW = PULSE_W + FW;
    localparam int SSW = SAT_W + FW;

    reading_t mem [MAX_WINDOW];
    reading_t rd_reg;

    extremes_t              ext_reg;
    logic signed [TSW-1:0]  tsum_reg;
    logic [PSW-1:0]         psum_reg;
    logic [SSW-1:0]         ssum_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            mem[addr] <= wr_data;
        end
        if (ctrl.rd) begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clr) begin
            ext_reg.tmin <= TEMP_MIN_INIT;
            ext_reg.tmax <= TEMP_MAX_INIT;
            ext_reg.pmin <= PULSE_MIN_INIT;
            ext_reg.pmax <= '0;
            ext_reg.smin <= SAT_MIN_INIT;
            ext_reg.smax <= '0;
            tsum_reg     <= '0;
            psum_reg     <= '0;
            ssum_reg     <= '0;
        end else if (ctrl.acc) begin
            if (rd_reg.temp < ext_reg.tmin) begin
                ext_reg.tmin <= rd_reg.temp;
            end
            if (rd_reg.temp > ext_reg.tmax) begin
                ext_reg.tmax <= rd_reg.temp;
            end
            if (rd_reg.pulse < ext_reg.pmin) begin
                ext_reg.pmin <= rd_reg.pulse;
            end
            if (rd_reg.pulse > ext_reg.pmax) begin
                ext_reg.pmax <= rd_reg.pulse;
            end
            if (rd_reg.sat < ext_reg.smin) begin
                ext_reg.smin <= rd_reg.sat;
            end
            if (rd_reg.sat > ext_reg.smax) begin
                ext_reg.smax <= rd_reg.sat;
            end
            tsum_reg <= tsum_reg + TSW'(rd_reg.temp);
            psum_reg <= psum_reg + PSW'(rd_reg.pulse);
            ssum_reg <= ssum_reg + SSW'(rd_reg.sat);
        end
    end

    assign ext  = ext_reg;
    assign tsum = tsum_reg;
    assign psum = psum_reg;
    assign ssum = ssum_reg;

endmodule

// ----- hdl/swmm_div.sv -----
// ---------------------------------------------------------------------------
// Sliding window min/max/mean: shared divider
// Restoring divider, one quotient bit per cycle, QUO_W quotient bits.
// The dividend's upper part must be below the divisor.
// ---------------------------------------------------------------------------
module swmm_div import swmm_pkg::*; #(
    parameter int FW = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [QUO_W+FW-1:0]    dividend,
    input  logic [FW-1:0]          divisor,
    output div_stat_t              stat,
    output logic [QUO_W-1:0]       quotient
);

    logic [FW-1:0]     rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [FW:0] trial;
    logic [FW:0] diff;
    logic        ge;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCNT_W'(QUO_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == QCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[QUO_W+FW-1:QUO_W];
            quo_reg <= dividend[QUO_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[FW-1:0] : trial[FW-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- hdl/sliding_window_min_max_mean_top.sv -----
// ---------------------------------------------------------------------------
// Sliding window min/max/mean: top level
// Keeps the last window_length readings (0 as 1, capped at MAX_WINDOW) and
// reports per-channel min, max and mean over them after every request.
//
//   Channel   Ports                       Moves
//   s_        valid/ready + 3 fields      one reading per request
//   m_        valid/ready + 10 fields     one result per request
//   APB       psel/penable/pwrite/...     window_length at address 0
//
// Each request makes one memory read per held reading (1..MAX_WINDOW
// held) through the compare/add unit, then three 16-step divisions on
// the shared divider.
// s_ready is high only while idle. A finished result waits in the output
// register; the next request is taken once it has been loaded there.
// Synchronous active-low reset; window_length resets to 5, history empty.
// ---------------------------------------------------------------------------
`include "sliding_window_min_max_mean_top_defines.svh"

module sliding_window_min_max_mean_top import swmm_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [TEMP_W-1:0]   s_temperature,
    input  logic [PULSE_W-1:0]         s_pulse_rate,
    input  logic [SAT_W-1:0]           s_oxygen_saturation,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [TEMP_W-1:0]   m_temp_min,
    output logic signed [TEMP_W-1:0]   m_temp_max,
    output logic signed [TEMP_W-1:0]   m_temp_mean,
    output logic [PULSE_W-1:0]         m_pulse_min,
    output logic [PULSE_W-1:0]         m_pulse_max,
    output logic [PMEAN_W-1:0]         m_pulse_mean,
    output logic [SAT_W-1:0]           m_sat_min,
    output logic [SAT_W-1:0]           m_sat_max,
    output logic [SMEAN_W-1:0]         m_sat_mean,
    output logic [HELD_W-1:0]          m_held_count
);

    localparam int FW  = $clog2(MAX_WINDOW + 1);
    localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DW  = QUO_W + FW;
    localparam int TSW = TEMP_W + FW;
    localparam int PSW = PULSE_W + FW;
    localparam int SSW = SAT_W + FW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DIV_GO = 3'd2;
    localparam logic [2:0] ST_DIV_WT = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    win_len_reg;
    logic [AW-1:0]       wslot_reg, wslot_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [FW-1:0]       idx_reg, idx_next;
    logic                rd_pend_reg;
    logic [1:0]          div_sel_reg, div_sel_next;
    logic signed [TEMP_W-1:0] tmean_reg;
    logic [PMEAN_W-1:0]  pmean_reg;
    logic [SMEAN_W-1:0]  smean_reg;
    result_t             res_reg;
    logic                m_valid_reg;

    logic                cfg_wr;
    logic [FW-1:0]       w_eff;
    logic [AW-1:0]       slot;
    logic [FW-1:0]       slot_p1;
    logic                s_acc;
    logic                out_load;
    hist_ctrl_t          hctrl;
    logic [AW-1:0]       haddr;
    reading_t            in_rd;
    extremes_t           ext;
    logic signed [TSW-1:0] tsum;
    logic [PSW-1:0]      psum;
    logic [SSW-1:0]      ssum;
    logic [TSW-1:0]      tmag;
    logic                div_start;
    logic [DW-1:0]       dividend;
    div_stat_t           dstat;
    logic [QUO_W-1:0]    quotient;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_WINDOW);
    assign prdata = (paddr[PADDR_W-1:2] == REG_WINDOW) ? PDATA_W'(win_len_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= RESET_WINDOW;
        end else if (cfg_wr) begin
            win_len_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (win_len_reg == '0) begin
            w_eff = FW'(1);
        end else if (int'(win_len_reg) > MAX_WINDOW) begin
            w_eff = FW'(MAX_WINDOW);
        end else begin
            w_eff = FW'(win_len_reg);
        end
    end

    assign slot    = (FW'(wslot_reg) >= w_eff) ? '0 : wslot_reg;
    assign slot_p1 = FW'(slot) + FW'(1);
    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;

    assign in_rd.temp  = s_temperature;
    assign in_rd.pulse = s_pulse_rate;
    assign in_rd.sat   = s_oxygen_saturation;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        wslot_next   = wslot_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        div_sel_next = div_sel_reg;
        hctrl        = '0;
        haddr        = idx_reg[AW-1:0];
        div_start    = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                haddr = slot;
                if (s_acc) begin
                    hctrl.wr   = 1'b1;
                    hctrl.clr  = 1'b1;
                    wslot_next = (slot_p1 >= w_eff) ? '0 : slot_p1[AW-1:0];
                    if (fill_reg < w_eff) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                hctrl.acc = rd_pend_reg;
                if (idx_reg < fill_reg) begin
                    hctrl.rd = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end else if (!rd_pend_reg) begin
                    div_sel_next = DIV_TEMP;
                    state_next   = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WT;
            end
            ST_DIV_WT: begin
                if (dstat.done) begin
                    if (div_sel_reg == DIV_SAT) begin
                        state_next = ST_DONE;
                    end else begin
                        div_sel_next = div_sel_reg + 1'b1;
                        state_next   = ST_DIV_GO;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr) begin
            wslot_next = '0;
            fill_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wslot_reg   <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            div_sel_reg <= DIV_TEMP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wslot_reg   <= wslot_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= hctrl.rd;
            div_sel_reg <= div_sel_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    swmm_hist #(
        .MAX_WINDOW (MAX_WINDOW),
        .AW         (AW),
        .FW         (FW)
    ) u_hist (
        .aclk    (aclk),
        .ctrl    (hctrl),
        .addr    (haddr),
        .wr_data (in_rd),
        .ext     (ext),
        .tsum    (tsum),
        .psum    (psum),
        .ssum    (ssum)
    );

    // divider operand select; temperature divides by magnitude
    assign tmag = tsum[TSW-1] ? unsigned'(-tsum) : unsigned'(tsum);

    always_comb begin
        case (div_sel_reg)
            DIV_TEMP:  dividend = DW'(tmag);
            DIV_PULSE: dividend = DW'({psum, {FRAC_W{1'b0}}});
            DIV_SAT:   dividend = DW'({ssum, {FRAC_W{1'b0}}});
            default:   dividend = '0;
        endcase
    end

    swmm_div #(
        .FW (FW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (fill_reg),
        .stat     (dstat),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV_WT && dstat.done) begin
            case (div_sel_reg)
                DIV_TEMP:  tmean_reg <= tsum[TSW-1] ? -signed'(quotient) : signed'(quotient);
                DIV_PULSE: pmean_reg <= quotient[PMEAN_W-1:0];
                DIV_SAT:   smean_reg <= quotient[SMEAN_W-1:0];
                default:   tmean_reg <= tmean_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_reg.ext   <= ext;
            res_reg.tmean <= tmean_reg;
            res_reg.pmean <= pmean_reg;
            res_reg.smean <= smean_reg;
            res_reg.held  <= HELD_W'(fill_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_temp_min   = res_reg.ext.tmin;
    assign m_temp_max   = res_reg.ext.tmax;
    assign m_temp_mean  = res_reg.tmean;
    assign m_pulse_min  = res_reg.ext.pmin;
    assign m_pulse_max  = res_reg.ext.pmax;
    assign m_pulse_mean = res_reg.pmean;
    assign m_sat_min    = res_reg.ext.smin;
    assign m_sat_max    = res_reg.ext.smax;
    assign m_sat_mean   = res_reg.smean;
    assign m_held_count = res_reg.held;

    `SWMM_ASSERT_NEXT(a_accept_scan, s_acc, state_reg == ST_SCAN, "request did not start scan")
    `SWMM_ASSERT_ALWAYS(a_fill_bound, fill_reg <= w_eff, "fill level above window")
    `SWMM_ASSERT_IMP(a_out_from_done, $rose(m_valid), $past(state_reg == ST_DONE), "result without done")
    `SWMM_ASSERT_IMP(a_div_idle, div_start, !dstat.busy, "divider started while busy")

endmodule

// ----- tb/sliding_window_min_max_mean_top_tb.sv -----
// ---------------------------------------------------------------------------
// Sliding window min/max/mean: testbench
// Sends vital-sign readings through the valid/ready input channel, keeps its
// own model of the reading window and compares every result field by field.
// The window length is reprogrammed over APB and read back between phases.
// ---------------------------------------------------------------------------
module sliding_window_min_max_mean_top_tb;
    import swmm_pkg::*;

    localparam int unsigned RANDOM_READINGS = 1450;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 80;

    class window_stats_board;
        logic signed [TEMP_W-1:0] temp_log [MAX_WINDOW_DEF];
        logic [PULSE_W-1:0]       pulse_log[MAX_WINDOW_DEF];
        logic [SAT_W-1:0]         sat_log  [MAX_WINDOW_DEF];
        int unsigned              wr_slot;
        int unsigned              held;
        logic [CFG_W-1:0]         win_len;
        result_t                  stats_due[$];
        int unsigned              mismatches;
        int unsigned              checked;
        string field_name[10] = '{"temp_min", "temp_max", "temp_mean", "pulse_min",
                                  "pulse_max", "pulse_mean", "sat_min", "sat_max",
                                  "sat_mean", "held_count"};

        function new();
            win_len    = RESET_WINDOW;
            wr_slot    = 0;
            held       = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] len);
            win_len = len;
            wr_slot = 0;
            held    = 0;
        endfunction

        function void take_reading(reading_t r);
            result_t     e;
            int unsigned eff;
            int unsigned slot;
            int          tsum;
            int unsigned psum;
            int unsigned ssum;
            eff  = (win_len == 0) ? 1 :
                   (win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(win_len);
            slot = (wr_slot >= eff) ? 0 : wr_slot;
            temp_log[slot]  = r.temp;
            pulse_log[slot] = r.pulse;
            sat_log[slot]   = r.sat;
            wr_slot = (slot + 1 >= eff) ? 0 : slot + 1;
            if (held < eff) held++;
            if (held > eff) held = eff;

            e.ext.tmin = TEMP_MIN_INIT;
            e.ext.tmax = TEMP_MAX_INIT;
            e.ext.pmin = PULSE_MIN_INIT;
            e.ext.pmax = '0;
            e.ext.smin = SAT_MIN_INIT;
            e.ext.smax = '0;
            tsum = 0;
            psum = 0;
            ssum = 0;
            for (int unsigned i = 0; i < held; i++) begin
                if (temp_log[i] < e.ext.tmin) e.ext.tmin = temp_log[i];
                if (temp_log[i] > e.ext.tmax) e.ext.tmax = temp_log[i];
                if (pulse_log[i] < e.ext.pmin) e.ext.pmin = pulse_log[i];
                if (pulse_log[i] > e.ext.pmax) e.ext.pmax = pulse_log[i];
                if (sat_log[i] < e.ext.smin) e.ext.smin = sat_log[i];
                if (sat_log[i] > e.ext.smax) e.ext.smax = sat_log[i];
                tsum += temp_log[i];
                psum += pulse_log[i];
                ssum += sat_log[i];
            end
            // integer division truncates toward zero
            e.tmean = TEMP_W'(tsum / int'(held));
            e.pmean = PMEAN_W'((psum * 16) / held);
            e.smean = SMEAN_W'((ssum * 16) / held);
            e.held  = HELD_W'(held);
            stats_due.insert(stats_due.size(), e);
        endfunction

        function void compare_stats(result_t got);
            result_t            want;
            logic signed [31:0] want_v[10];
            logic signed [31:0] got_v[10];
            if (stats_due.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                mismatches++;
                return;
            end
            want = stats_due.pop_front();
            checked++;
            want_v = '{want.ext.tmin, want.ext.tmax, want.tmean, want.ext.pmin,
                       want.ext.pmax, want.pmean, want.ext.smin, want.ext.smax,
                       want.smean, want.held};
            got_v  = '{got.ext.tmin, got.ext.tmax, got.tmean, got.ext.pmin,
                       got.ext.pmax, got.pmean, got.ext.smin, got.ext.smax,
                       got.smean, got.held};
            for (int i = 0; i < 10; i++) begin
                if (got_v[i] !== want_v[i]) begin
                    $display("%0t: %s expected %0d, got %0d", $time, field_name[i],
                             want_v[i], got_v[i]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [TEMP_W-1:0] s_temperature;
    logic [PULSE_W-1:0]       s_pulse_rate;
    logic [SAT_W-1:0]         s_oxygen_saturation;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [TEMP_W-1:0] m_temp_min;
    logic signed [TEMP_W-1:0] m_temp_max;
    logic signed [TEMP_W-1:0] m_temp_mean;
    logic [PULSE_W-1:0]       m_pulse_min;
    logic [PULSE_W-1:0]       m_pulse_max;
    logic [PMEAN_W-1:0]       m_pulse_mean;
    logic [SAT_W-1:0]         m_sat_min;
    logic [SAT_W-1:0]         m_sat_max;
    logic [SMEAN_W-1:0]       m_sat_mean;
    logic [HELD_W-1:0]        m_held_count;

    window_stats_board board = new();
    int unsigned       sent;
    int unsigned       window_writes;
    int unsigned       src_idle_pct;
    int unsigned       sink_idle_pct;
    int unsigned       sink_hold;

    sliding_window_min_max_mean_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_temperature       (s_temperature),
        .s_pulse_rate        (s_pulse_rate),
        .s_oxygen_saturation (s_oxygen_saturation),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temp_min          (m_temp_min),
        .m_temp_max          (m_temp_max),
        .m_temp_mean         (m_temp_mean),
        .m_pulse_min         (m_pulse_min),
        .m_pulse_max         (m_pulse_max),
        .m_pulse_mean        (m_pulse_mean),
        .m_sat_min           (m_sat_min),
        .m_sat_max           (m_sat_max),
        .m_sat_mean          (m_sat_mean),
        .m_held_count        (m_held_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (sink_hold != 0) begin
            m_ready <= 1'b0;
            sink_hold--;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.ext.tmin = m_temp_min;
            got.ext.tmax = m_temp_max;
            got.ext.pmin = m_pulse_min;
            got.ext.pmax = m_pulse_max;
            got.ext.smin = m_sat_min;
            got.ext.smax = m_sat_max;
            got.tmean    = m_temp_mean;
            got.pmean    = m_pulse_mean;
            got.smean    = m_sat_mean;
            got.held     = m_held_count;
            board.compare_stats(got);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_reading(input reading_t r);
        int unsigned gap;
        gap = (src_idle_pct != 0 && $urandom_range(15) == 0) ? $urandom_range(1, 80) : 0;
        while (gap != 0 || $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            if (gap != 0) gap--;
        end
        s_valid             <= 1'b1;
        s_temperature       <= r.temp;
        s_pulse_rate        <= r.pulse;
        s_oxygen_saturation <= r.sat;
        do @(posedge aclk); while (!s_ready);
        board.take_reading(r);
        sent++;
        @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_WINDOW, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain, then write the window length and read it back
    task automatic program_window(input logic [CFG_W-1:0] len);
        logic [PDATA_W-1:0] rd;
        s_valid <= 1'b0;
        @(negedge aclk);
        while (board.stats_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        apb_access(1'b1, {28'($urandom), len}, rd);
        board.set_window(len);
        window_writes++;
        @(negedge aclk);
        apb_access(1'b0, '0, rd);
        if (rd !== PDATA_W'(len)) begin
            $display("%0t: window_length read-back expected %0d, got %0d", $time, len, rd);
            board.mismatches++;
        end
    endtask

    function automatic reading_t random_reading();
        reading_t r;
        case ($urandom_range(9))
            0, 1, 2: r.temp = TEMP_W'($urandom);
            3: begin
                case ($urandom_range(3))
                    0: r.temp = 16'sh8000;
                    1: r.temp = 16'sh7FFF;
                    2: r.temp = 16'shFFFF;
                    default: r.temp = 16'sh0000;
                endcase
            end
            4: r.temp = TEMP_W'($urandom_range(600)) - 16'sd300;
            default: r.temp = TEMP_W'($urandom_range(3400, 4100));
        endcase
        case ($urandom_range(9))
            0, 1: r.pulse = PULSE_W'($urandom);
            2: r.pulse = $urandom_range(1) ? 8'hFF : 8'h00;
            default: r.pulse = PULSE_W'($urandom_range(50, 160));
        endcase
        case ($urandom_range(9))
            0, 1: r.sat = SAT_W'($urandom);
            2: begin
                case ($urandom_range(2))
                    0: r.sat = 7'd0;
                    1: r.sat = 7'd100;
                    default: r.sat = 7'd127;
                endcase
            end
            default: r.sat = SAT_W'($urandom_range(85, 100));
        endcase
        return r;
    endfunction

    initial begin
        #(12 * 1000000);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned      goal;
        int unsigned      seg_len;
        int unsigned      done_rand;
        logic [CFG_W-1:0] len;
        bit               pressed;
        aresetn             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        s_valid             = 1'b0;
        s_temperature       = '0;
        s_pulse_rate        = '0;
        s_oxygen_saturation = '0;
        m_ready             = 1'b0;
        sink_hold           = 0;
        src_idle_pct        = 0;
        sink_idle_pct       = 0;
        sent                = 0;
        window_writes       = 0;
        pressed             = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset window of five, wraps after the fifth reading
        send_reading(reading_t'{16'sh7FFF, 8'hFF, 7'h7F});
        send_reading(reading_t'{16'sh8000, 8'h00, 7'h00});
        send_reading(reading_t'{16'shFFFF, 8'h01, 7'd100});
        send_reading(reading_t'{16'shFFFE, 8'h80, 7'h40});
        send_reading(reading_t'{16'sh0000, 8'h7F, 7'h3F});
        send_reading(reading_t'{16'sh5555, 8'h55, 7'h55});
        send_reading(reading_t'{16'shAAAA, 8'hAA, 7'h2A});
        program_window(4'd1);
        send_reading(reading_t'{16'shFFFD, 8'h07, 7'h03});
        send_reading(reading_t'{16'sh0003, 8'h08, 7'h04});
        // zero acts as one
        program_window(4'd0);
        send_reading(reading_t'{16'sh8000, 8'hFF, 7'h7F});
        send_reading(reading_t'{16'sh7FFF, 8'h00, 7'h00});
        program_window(4'd8);
        send_reading(reading_t'{16'shFFFF, 8'd72, 7'd98});
        send_reading(reading_t'{16'shFFFF, 8'd75, 7'd97});
        send_reading(reading_t'{16'shFFFE, 8'd71, 7'd99});
        send_reading(reading_t'{16'sh0E74, 8'd80, 7'd95});
        send_reading(reading_t'{16'sh0E10, 8'd64, 7'd100});
        send_reading(reading_t'{16'shF000, 8'd200, 7'd90});
        send_reading(reading_t'{16'sh0FA0, 8'd33, 7'd120});
        send_reading(reading_t'{16'sh0001, 8'd1, 7'd1});
        send_reading(reading_t'{16'sh7FFF, 8'hFF, 7'h7F});
        send_reading(reading_t'{16'sh8000, 8'h00, 7'h00});
        // above the maximum saturates to eight
        program_window(4'd15);
        send_reading(reading_t'{16'sh0E80, 8'd90, 7'd96});
        send_reading(reading_t'{16'sh8001, 8'd254, 7'd126});
        send_reading(reading_t'{16'sh7FFE, 8'd2, 7'd2});

        goal      = sent + RANDOM_READINGS;
        done_rand = 0;
        while (sent < goal) begin
            done_rand = sent + RANDOM_READINGS - goal;
            if (done_rand < RANDOM_READINGS / 3) begin
                src_idle_pct  = 24;
                sink_idle_pct = 76;
            end else if (done_rand < 2 * RANDOM_READINGS / 3) begin
                src_idle_pct  = 76;
                sink_idle_pct = 24;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0: len = 4'd0;
                    1: len = 4'd1;
                    2: len = 4'd8;
                    default: len = 4'd15;
                endcase
            end else begin
                len = CFG_W'($urandom);
            end
            program_window(len);
            if (!pressed && src_idle_pct == 0) begin
                sink_hold = HOLD_OFF_CYCLES;
                pressed   = 1'b1;
            end
            seg_len = $urandom_range(20, 70);
            repeat (seg_len) begin
                if (sent < goal) send_reading(random_reading());
            end
        end

        s_valid <= 1'b0;
        while (board.stats_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("summary: %0d readings sent, %0d results compared, %0d mismatches",
                 sent, board.checked, board.mismatches);
        $display("summary: %0d window-length writes, each read back, lengths 0 to 15",
                 window_writes);
        if (board.mismatches == 0 && board.stats_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/swmm_pkg.sv
hdl/swmm_hist.sv
hdl/swmm_div.sv
hdl/sliding_window_min_max_mean_top.sv
tb/sliding_window_min_max_mean_top_tb.sv
